FILE: rtl/lsrk_pkg.sv
package lsrk_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    // Stream payload layout
    localparam int KEY_W     = 16;
    localparam int FUNC_W    = 2;
    localparam int OUT_ID_W  = 16;
    localparam int STS_W     = 3;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - OUT_ID_W - STS_W;

    // Width used when ids and keys are compared or narrowed to the output field
    localparam int EXT_W = (ID_BITS > KEY_W) ? ID_BITS : KEY_W;

    typedef logic [ID_BITS-1:0] id_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_SHOW   = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_FULL      = 3'd1,
        STS_EMPTY     = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_OVERFLOW  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SHOW,
        ST_RM_CMP,
        ST_RM_DEL
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // input transaction accepted
        logic push;     // execute push, emit one result
        logic show;     // emit one listing result
        logic compare;  // register per-cell key matches
        logic remove;   // delete topmost match, emit one result
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        func_t in_func;    // operation on the input channel
        logic  out_free;   // output register can take a result this cycle
        logic  show_done;  // current listing result is the final one
    } sts_t;

endpackage

FILE: rtl/lsrk_ctrl.sv
module lsrk_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  lsrk_pkg::sts_t  sts,
    output lsrk_pkg::cmd_t  cmd
);
    import lsrk_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    unique case (sts.in_func)
                        FUNC_PUSH:   state_next = ST_PUSH;
                        FUNC_SHOW:   state_next = ST_SHOW;
                        FUNC_REMOVE: state_next = ST_RM_CMP;
                        FUNC_NONE:   state_next = ST_IDLE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PUSH: begin
                if (sts.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SHOW: begin
                if (sts.out_free) begin
                    cmd.show = 1'b1;
                    if (sts.show_done) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RM_CMP: begin
                cmd.compare = 1'b1;
                state_next  = ST_RM_DEL;
            end
            ST_RM_DEL: begin
                if (sts.out_free) begin
                    cmd.remove = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/lsrk_dp.sv
module lsrk_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [lsrk_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [lsrk_pkg::FUNC_W-1:0]      s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsrk_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    input  lsrk_pkg::cmd_t                   cmd,
    output lsrk_pkg::sts_t                   sts
);
    import lsrk_pkg::*;

    // Stack cells, slot 0 at the bottom
    id_t                   store_reg [STACK_DEPTH];
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      rd_addr_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [STACK_DEPTH-1:0] match_reg;

    // Output register
    logic                  m_valid_reg;
    logic [OUT_ID_W-1:0]   m_id_reg;
    status_t               m_status_reg;
    logic                  m_last_reg;

    logic                  out_free;
    logic                  emit;
    id_t                   rd_data;
    logic [EXT_W-1:0]      rd_ext;
    logic [EXT_W-1:0]      key_ext;
    logic                  is_empty;
    logic                  is_full;
    logic                  top_at_max;
    id_t                   push_id;
    logic [EXT_W-1:0]      push_ext;
    logic [STACK_DEPTH-1:0] match_now;
    logic [STACK_DEPTH-1:0] shift_en;
    logic                  found;

    assign out_free   = !m_valid_reg || m_tready;
    assign emit       = cmd.push || cmd.show || cmd.remove;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign rd_data    = store_reg[rd_addr_reg];
    assign rd_ext     = EXT_W'(rd_data);
    assign key_ext    = EXT_W'(key_reg);
    assign top_at_max = (rd_data == '1);
    assign push_id    = is_empty ? id_t'(1) : id_t'(rd_data + id_t'(1));
    assign push_ext   = EXT_W'(push_id);
    assign found      = |match_reg;

    // Per-cell key compare, only cells below the fill count take part
    always_comb begin
        for (int k = 0; k < STACK_DEPTH; k++) begin
            match_now[k] = (k < int'(count_reg)) && (EXT_W'(store_reg[k]) == key_ext);
        end
    end

    // A cell shifts down when no match lies above it, i.e. at or above the topmost match
    always_comb begin
        for (int j = 0; j < STACK_DEPTH; j++) begin
            shift_en[j] = ((match_reg >> (j + 1)) == '0);
        end
    end

    // Status back to the controller
    always_comb begin
        sts.in_func   = func_t'(s_tuser);
        sts.out_free  = out_free;
        sts.show_done = is_empty || (rd_addr_reg == '0);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.push && !is_full && !(!is_empty && top_at_max)) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.remove && found) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Operand latch, read pointer and match vector
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg     <= s_tdata[KEY_W-1:0];
            rd_addr_reg <= IDX_W'(count_reg - CNT_W'(1));
        end else if (cmd.show) begin
            rd_addr_reg <= rd_addr_reg - IDX_W'(1);
        end
        if (cmd.compare) begin
            match_reg <= match_now;
        end
    end

    // Stack cells: write on push, shift down on remove
    always_ff @(posedge aclk) begin
        for (int j = 0; j < STACK_DEPTH; j++) begin
            if (cmd.push && !is_full && !(!is_empty && top_at_max)
                    && (count_reg[IDX_W-1:0] == IDX_W'(j))) begin
                store_reg[j] <= push_id;
            end else if (cmd.remove && found && shift_en[j] && (j < STACK_DEPTH - 1)) begin
                store_reg[j] <= store_reg[(j + 1) % STACK_DEPTH];
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_last_reg <= 1'b1;
            if (is_full) begin
                m_id_reg     <= '0;
                m_status_reg <= STS_FULL;
            end else if (!is_empty && top_at_max) begin
                m_id_reg     <= '0;
                m_status_reg <= STS_OVERFLOW;
            end else begin
                m_id_reg     <= push_ext[OUT_ID_W-1:0];
                m_status_reg <= STS_OK;
            end
        end else if (cmd.show) begin
            if (is_empty) begin
                m_id_reg     <= '0;
                m_status_reg <= STS_EMPTY;
                m_last_reg   <= 1'b1;
            end else begin
                m_id_reg     <= rd_ext[OUT_ID_W-1:0];
                m_status_reg <= STS_OK;
                m_last_reg   <= (rd_addr_reg == '0);
            end
        end else if (cmd.remove) begin
            m_last_reg <= 1'b1;
            if (found) begin
                // the removed id equals the key
                m_id_reg     <= key_reg;
                m_status_reg <= STS_OK;
            end else begin
                m_id_reg     <= '0;
                m_status_reg <= STS_NOT_FOUND;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), m_status_reg, m_id_reg};
    assign m_tlast  = m_last_reg;

    // Fill count stays within the stack
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("fill count beyond stack depth");

    // Results are only produced into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result produced while output register busy");

    // A successful remove drops exactly one entry
    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.remove && found) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not shrink the stack by one");

    // The match vector never flags a cell above the fill count
    a_match_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.compare |=> ((match_reg >> count_reg) == '0))
        else $error("match flagged outside stored entries");

endmodule

FILE: rtl/lifo_stack_remove_by_key_unit.sv
// LIFO stack of entry ids with remove by key. Each input transaction carries an
// operation in s_tuser (push, show, remove) and a key in s_tdata. Push returns
// the new id (top id plus one, or 1 on an empty stack) or a full/overflow status;
// remove deletes the topmost entry equal to the key and keeps the order of the
// rest (registered per-cell compare, then a parallel shift of the cells above the
// match); show emits one id per cycle from top to bottom while m_tready does not
// stall the output, read through the single read port of the cell array and the
// one-deep output register. An empty show gives one empty status result. m_tlast
// marks the final result of each operation; the unused operation code produces
// no result. Every result can be held in the output register by m_tready. A new
// transaction is taken once the previous one has handed its last result to the
// output register.
module lifo_stack_remove_by_key_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lsrk_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] key
    input  logic [lsrk_pkg::FUNC_W-1:0]      s_tuser,   // [1:0] func
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lsrk_pkg::M_TDATA_W-1:0]   m_tdata,   // [15:0] entry_id, [18:16] status
    output logic                             m_tlast
);
    import lsrk_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lsrk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lsrk_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
